// File: hw/rtl/rbox_pkg.sv
package rbox_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_RED     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_GREEN   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_BLUE    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_ALPHA   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INK_RED      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INK_GREEN    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INK_BLUE     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BORDER_WIDTH = 4'd7;

    // Register reset values.
    localparam logic [7:0] RST_FILL_COLOR   = 8'd0;
    localparam logic [7:0] RST_FILL_ALPHA   = 8'd192;
    localparam logic [7:0] RST_INK_COLOR    = 8'd255;
    localparam logic [5:0] RST_BORDER_WIDTH = 6'd0;

    // Opacity of the border band.
    localparam logic [7:0] BORDER_ALPHA = 8'd180;
    localparam logic [7:0] FULL_SCALE   = 8'd255;

    typedef enum logic [1:0] {
        REGION_OUTSIDE  = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_BORDER   = 2'd2
    } region_t;

    typedef struct packed {
        logic [7:0] fill_red;
        logic [7:0] fill_green;
        logic [7:0] fill_blue;
        logic [7:0] fill_alpha;
        logic [7:0] ink_red;
        logic [7:0] ink_green;
        logic [7:0] ink_blue;
        logic [5:0] border_width;
    } rbox_cfg_t;

    // What the geometry stages hand to the blend stages for one pixel.
    typedef struct packed {
        region_t    region;
        logic [7:0] alpha;
        logic [7:0] coverage;
    } rbox_geo_t;

endpackage

// File: hw/rtl/rbox_if.sv
interface rbox_pix_if;
    logic       valid;
    logic       ready;
    logic [9:0] pixel_x;
    logic [6:0] pixel_y;
    logic [7:0] text_coverage;

    modport source (output valid, pixel_x, pixel_y, text_coverage, input ready);
    modport sink (input valid, pixel_x, pixel_y, text_coverage, output ready);
endinterface

interface rbox_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [1:0] region;

    modport source (output valid, out_alpha, out_red, out_green, out_blue, region,
                    input ready);
    modport sink (input valid, out_alpha, out_red, out_green, out_blue, region,
                  output ready);
endinterface

interface rbox_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rbox_pkg::CFG_INDEX_W-1:0]   index;
    logic [rbox_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rbox_geom.sv
module rbox_geom #(
    parameter int FRAME_WIDTH   = 900,
    parameter int FRAME_HEIGHT  = 120,
    parameter int BOX_INSET     = 16,
    parameter int CORNER_RADIUS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [9:0]          pixel_x,
    input  logic [6:0]          pixel_y,
    input  logic [7:0]          text_coverage,
    input  rbox_pkg::rbox_cfg_t cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output rbox_pkg::rbox_geo_t out_geo
);

    localparam int CoordW = 14;
    typedef logic signed [CoordW-1:0] coord_t;

    localparam coord_t BOX_W  = coord_t'(FRAME_WIDTH - 2 * BOX_INSET);
    localparam coord_t BOX_H  = coord_t'(FRAME_HEIGHT - 2 * BOX_INSET);
    localparam coord_t INSET  = coord_t'(BOX_INSET);
    localparam coord_t RADIUS = coord_t'(CORNER_RADIUS);
    localparam logic [17:0] OUTER_RR = 18'(CORNER_RADIUS * CORNER_RADIUS);

    typedef struct packed {
        logic              inrange;
        logic              band;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
    } prep_t;

    typedef struct packed {
        logic        inrange;
        logic        band;
        logic [16:0] sq_x;
        logic [16:0] sq_y;
    } squares_t;

    // Splits the rounded-box test into the cheap range checks and the corner
    // offsets. The offsets only matter in a corner, where they stay within 9 bits.
    function automatic prep_t box_prep(input coord_t x, input coord_t y,
                                       input coord_t w, input coord_t h,
                                       input coord_t r);
        prep_t  p;
        coord_t ccx;
        coord_t ccy;
        coord_t ddx;
        coord_t ddy;
        p.inrange = (x >= 0) && (y >= 0) && (x < w) && (y < h);
        p.band    = ((x >= r) && (x < w - r)) || ((y >= r) && (y < h - r));
        ccx       = (x < r) ? r : w - r - coord_t'(1);
        ccy       = (y < r) ? r : h - r - coord_t'(1);
        ddx       = x - ccx;
        ddy       = y - ccy;
        p.dx      = ddx[8:0];
        p.dy      = ddy[8:0];
        return p;
    endfunction

    function automatic logic [16:0] sq9(input logic signed [8:0] v);
        logic signed [17:0] prod;
        prod = v * v;
        return prod[16:0];
    endfunction

    // Stage 1: range checks and corner offsets for the outer and inner boxes.
    logic       s1_valid_reg;
    prep_t      s1_outer_reg, s1_outer_next;
    prep_t      s1_inner_reg, s1_inner_next;
    logic [7:0] s1_inner_r_reg, s1_inner_r_next;
    logic       s1_border_on_reg;
    logic [7:0] s1_cov_reg;

    // Stage 2: squared offsets.
    logic        s2_valid_reg;
    squares_t    s2_outer_reg, s2_outer_next;
    squares_t    s2_inner_reg, s2_inner_next;
    logic [15:0] s2_inner_rr_reg;
    logic        s2_border_on_reg;
    logic [7:0]  s2_cov_reg;

    // Stage 3: region decision.
    logic                s3_valid_reg;
    rbox_pkg::rbox_geo_t s3_geo_reg, s3_geo_next;

    logic en1, en2, en3;

    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        coord_t bx;
        coord_t by;
        coord_t bw;
        logic   in_frame;
        bx       = coord_t'({4'b0, pixel_x}) - INSET;
        by       = coord_t'({7'b0, pixel_y}) - INSET;
        bw       = coord_t'({8'b0, cfg.border_width});
        in_frame = ({4'b0, pixel_x} < 14'(FRAME_WIDTH)) &&
                   ({7'b0, pixel_y} < 14'(FRAME_HEIGHT));

        s1_outer_next         = box_prep(bx, by, BOX_W, BOX_H, RADIUS);
        s1_outer_next.inrange = s1_outer_next.inrange && in_frame;
        s1_inner_next         = box_prep(bx - bw, by - bw, BOX_W - (bw + bw),
                                         BOX_H - (bw + bw), RADIUS - bw);
        // Inner radius clamps at zero; a zero radius makes the box square.
        if (bw >= RADIUS)
        begin
            s1_inner_r_next = 8'd0;
            s1_inner_next   = box_prep(bx - bw, by - bw, BOX_W - (bw + bw),
                                       BOX_H - (bw + bw), coord_t'(0));
        end
        else
        begin
            s1_inner_r_next = 8'(RADIUS - bw);
        end
    end

    always_comb
    begin
        s2_outer_next.inrange = s1_outer_reg.inrange;
        s2_outer_next.band    = s1_outer_reg.band;
        s2_outer_next.sq_x    = sq9(s1_outer_reg.dx);
        s2_outer_next.sq_y    = sq9(s1_outer_reg.dy);
        s2_inner_next.inrange = s1_inner_reg.inrange;
        s2_inner_next.band    = s1_inner_reg.band;
        s2_inner_next.sq_x    = sq9(s1_inner_reg.dx);
        s2_inner_next.sq_y    = sq9(s1_inner_reg.dy);
    end

    always_comb
    begin
        logic [17:0] outer_sum;
        logic [17:0] inner_sum;
        logic        outer_in;
        logic        inner_in;
        outer_sum = {1'b0, s2_outer_reg.sq_x} + {1'b0, s2_outer_reg.sq_y};
        inner_sum = {1'b0, s2_inner_reg.sq_x} + {1'b0, s2_inner_reg.sq_y};
        outer_in  = s2_outer_reg.inrange &&
                    (s2_outer_reg.band || (outer_sum <= OUTER_RR));
        inner_in  = s2_inner_reg.inrange &&
                    (s2_inner_reg.band || (inner_sum <= {2'b0, s2_inner_rr_reg}));

        s3_geo_next.coverage = s2_cov_reg;
        if (!outer_in)
        begin
            s3_geo_next.region = rbox_pkg::REGION_OUTSIDE;
            s3_geo_next.alpha  = 8'd0;
        end
        else if (s2_border_on_reg && !inner_in)
        begin
            s3_geo_next.region = rbox_pkg::REGION_BORDER;
            s3_geo_next.alpha  = rbox_pkg::BORDER_ALPHA;
        end
        else
        begin
            s3_geo_next.region = rbox_pkg::REGION_INTERIOR;
            s3_geo_next.alpha  = cfg.fill_alpha;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_outer_reg     <= s1_outer_next;
            s1_inner_reg     <= s1_inner_next;
            s1_inner_r_reg   <= s1_inner_r_next;
            s1_border_on_reg <= (cfg.border_width != 6'd0);
            s1_cov_reg       <= text_coverage;
        end
        if (en2)
        begin
            s2_outer_reg     <= s2_outer_next;
            s2_inner_reg     <= s2_inner_next;
            s2_inner_rr_reg  <= s1_inner_r_reg * s1_inner_r_reg;
            s2_border_on_reg <= s1_border_on_reg;
            s2_cov_reg       <= s1_cov_reg;
        end
        if (en3)
        begin
            s3_geo_reg <= s3_geo_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_geo   = s3_geo_reg;

endmodule

// File: hw/rtl/rbox_blend.sv
module rbox_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbox_pkg::rbox_geo_t geo,
    input  rbox_pkg::rbox_cfg_t cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_alpha,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic [1:0]          region
);

    // Exact floor(p / 255) for every product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + 17'd1 + {9'b0, p[15:8]};
        return s[15:8];
    endfunction

    // Stage 1: fill color times background alpha.
    logic                b1_valid_reg;
    logic [15:0]         b1_pr_reg, b1_pg_reg, b1_pb_reg;
    rbox_pkg::rbox_geo_t b1_geo_reg;

    // Stage 2: premultiplied background.
    logic                b2_valid_reg;
    logic [7:0]          b2_bgr_reg, b2_bgg_reg, b2_bgb_reg;
    rbox_pkg::rbox_geo_t b2_geo_reg;

    // Stage 3: ink and background products.
    logic                b3_valid_reg;
    logic [15:0]         b3_ir_reg, b3_ig_reg, b3_ib_reg;
    logic [15:0]         b3_br_reg, b3_bg_reg, b3_bb_reg;
    logic [15:0]         b3_ba_reg;
    logic [7:0]          b3_cov_reg;
    rbox_pkg::region_t   b3_region_reg;

    // Stage 4: output word.
    logic                b4_valid_reg;
    logic [7:0]          b4_alpha_reg, b4_red_reg, b4_green_reg, b4_blue_reg;
    rbox_pkg::region_t   b4_region_reg;

    logic       en1, en2, en3, en4;
    logic [7:0] inv;

    assign en4      = !b4_valid_reg || out_ready;
    assign en3      = !b3_valid_reg || en4;
    assign en2      = !b2_valid_reg || en3;
    assign en1      = !b1_valid_reg || en2;
    assign in_ready = en1;
    assign inv      = rbox_pkg::FULL_SCALE - b2_geo_reg.coverage;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                b1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (en3)
            begin
                b3_valid_reg <= b2_valid_reg;
            end
            if (en4)
            begin
                b4_valid_reg <= b3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            b1_pr_reg  <= cfg.fill_red * geo.alpha;
            b1_pg_reg  <= cfg.fill_green * geo.alpha;
            b1_pb_reg  <= cfg.fill_blue * geo.alpha;
            b1_geo_reg <= geo;
        end
        if (en2)
        begin
            b2_bgr_reg <= div255(b1_pr_reg);
            b2_bgg_reg <= div255(b1_pg_reg);
            b2_bgb_reg <= div255(b1_pb_reg);
            b2_geo_reg <= b1_geo_reg;
        end
        if (en3)
        begin
            // With zero coverage the ink terms vanish and inv is full scale,
            // so the background passes through unchanged.
            b3_ir_reg     <= cfg.ink_red * b2_geo_reg.coverage;
            b3_ig_reg     <= cfg.ink_green * b2_geo_reg.coverage;
            b3_ib_reg     <= cfg.ink_blue * b2_geo_reg.coverage;
            b3_br_reg     <= b2_bgr_reg * inv;
            b3_bg_reg     <= b2_bgg_reg * inv;
            b3_bb_reg     <= b2_bgb_reg * inv;
            b3_ba_reg     <= b2_geo_reg.alpha * inv;
            b3_cov_reg    <= b2_geo_reg.coverage;
            b3_region_reg <= b2_geo_reg.region;
        end
        if (en4)
        begin
            b4_alpha_reg  <= b3_cov_reg + div255(b3_ba_reg);
            b4_red_reg    <= div255(b3_ir_reg) + div255(b3_br_reg);
            b4_green_reg  <= div255(b3_ig_reg) + div255(b3_bg_reg);
            b4_blue_reg   <= div255(b3_ib_reg) + div255(b3_bb_reg);
            b4_region_reg <= b3_region_reg;
        end
    end

    assign out_valid = b4_valid_reg;
    assign out_alpha = b4_alpha_reg;
    assign out_red   = b4_red_reg;
    assign out_green = b4_green_reg;
    assign out_blue  = b4_blue_reg;
    assign region    = b4_region_reg;

endmodule

// File: hw/rtl/rounded_box_overlay_compositor.sv
// Rounded box overlay compositor.
// The pix channel takes one word per pixel: its column, row and text coverage.
// The res channel returns one premultiplied ARGB word per pixel together with
// a region code (outside the box, box interior, border band), in input order.
// The cfg channel writes the fill color, fill alpha, ink color and border
// width by register index; it is always ready and a write takes effect at
// once, so the user must write it only while no pixel is in flight; the
// block itself does not enforce this. Throughput is one pixel per clock
// while res is ready. Seven register stages lie between pix and res: three
// of box geometry (range checks, squared corner offsets, radius compare)
// and four of blending (fill products, divide by 255, ink and background
// products, final divide and sum).
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up when res stalls and pix keeps
// being accepted until every stage holds a pixel. A stalled result holds.
// Reset empties the pipeline and returns the registers to their defaults:
// black fill at alpha 192, white ink, no border.
module rounded_box_overlay_compositor #(
    parameter int FRAME_WIDTH   = 900,
    parameter int FRAME_HEIGHT  = 120,
    parameter int BOX_INSET     = 16,
    parameter int CORNER_RADIUS = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    rbox_pix_if.sink   pix,
    rbox_res_if.source res,
    rbox_cfg_if.sink   cfg
);

    rbox_pkg::rbox_cfg_t cfg_reg;
    rbox_pkg::rbox_geo_t geo;
    logic                geo_valid;
    logic                geo_ready;

    // Configuration registers. Unknown indexes are dropped; the border width
    // keeps the low six bits of the written data.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_red     <= rbox_pkg::RST_FILL_COLOR;
            cfg_reg.fill_green   <= rbox_pkg::RST_FILL_COLOR;
            cfg_reg.fill_blue    <= rbox_pkg::RST_FILL_COLOR;
            cfg_reg.fill_alpha   <= rbox_pkg::RST_FILL_ALPHA;
            cfg_reg.ink_red      <= rbox_pkg::RST_INK_COLOR;
            cfg_reg.ink_green    <= rbox_pkg::RST_INK_COLOR;
            cfg_reg.ink_blue     <= rbox_pkg::RST_INK_COLOR;
            cfg_reg.border_width <= rbox_pkg::RST_BORDER_WIDTH;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rbox_pkg::REG_FILL_RED:     cfg_reg.fill_red     <= cfg.data;
                rbox_pkg::REG_FILL_GREEN:   cfg_reg.fill_green   <= cfg.data;
                rbox_pkg::REG_FILL_BLUE:    cfg_reg.fill_blue    <= cfg.data;
                rbox_pkg::REG_FILL_ALPHA:   cfg_reg.fill_alpha   <= cfg.data;
                rbox_pkg::REG_INK_RED:      cfg_reg.ink_red      <= cfg.data;
                rbox_pkg::REG_INK_GREEN:    cfg_reg.ink_green    <= cfg.data;
                rbox_pkg::REG_INK_BLUE:     cfg_reg.ink_blue     <= cfg.data;
                rbox_pkg::REG_BORDER_WIDTH: cfg_reg.border_width <= cfg.data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // Geometry: decides the region and the background alpha of each pixel.
    rbox_geom #(
        .FRAME_WIDTH   (FRAME_WIDTH),
        .FRAME_HEIGHT  (FRAME_HEIGHT),
        .BOX_INSET     (BOX_INSET),
        .CORNER_RADIUS (CORNER_RADIUS)
    ) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pix.valid),
        .in_ready      (pix.ready),
        .pixel_x       (pix.pixel_x),
        .pixel_y       (pix.pixel_y),
        .text_coverage (pix.text_coverage),
        .cfg           (cfg_reg),
        .out_valid     (geo_valid),
        .out_ready     (geo_ready),
        .out_geo       (geo)
    );

    // Blend: premultiplies the fill and lays the ink over it.
    rbox_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .geo       (geo),
        .cfg       (cfg_reg),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_alpha (res.out_alpha),
        .out_red   (res.out_red),
        .out_green (res.out_green),
        .out_blue  (res.out_blue),
        .region    (res.region)
    );

    // The input is held off only when every stage is full and the output stalls.
    a_backpressure_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !pix.ready |-> (res.valid && !res.ready))
        else $error("input stalled while the pipeline has room");

    // A premultiplied color never exceeds its alpha.
    a_premultiplied: assert property (
        @(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.out_red <= res.out_alpha) &&
                      (res.out_green <= res.out_alpha) &&
                      (res.out_blue <= res.out_alpha))
        else $error("color channel above alpha");

    // A border pixel needs a border and an alpha of at least 179.
    a_border_band: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res.valid && (res.region == rbox_pkg::REGION_BORDER)) |->
            ((cfg_reg.border_width != 6'd0) && (res.out_alpha >= 8'd179)))
        else $error("border pixel without border or with low alpha");

endmodule

// File: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the overlay frame, matching the block's defaults.
    localparam int FRAME_W  = 900;
    localparam int FRAME_H  = 120;
    localparam int INSET    = 16;
    localparam int CORNER_R = 20;

    // Seven register stages sit between pix and res.
    localparam int PIPE_LATENCY = 7;
    localparam int PHASES = 8;
    localparam int PIXELS_PER_PHASE = 230;
    localparam int HOLD_CYCLES = 100;
    localparam int MAX_REPORTS = 50;

    // Several times the slowest legal run: every word waits out the longest
    // gap on both sides, plus the long hold-off and the drains between phases.
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    typedef struct packed {
        logic [9:0] x;
        logic [6:0] y;
        logic [7:0] coverage;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0]        alpha;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        rbox_pkg::region_t region;
    } pixel_out_t;

    typedef struct packed {
        logic [rbox_pkg::CFG_INDEX_W-1:0] index;
        logic [rbox_pkg::CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rbox_pix_if pix_if();
    rbox_res_if res_if();
    rbox_cfg_if cfg_if();

    rounded_box_overlay_compositor #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H),
        .BOX_INSET    (INSET),
        .CORNER_RADIUS(CORNER_R)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .pix  (pix_if),
        .res  (res_if),
        .cfg  (cfg_if)
    );

    always #5 clk = ~clk;

    // Pixels waiting to be offered, and the composited words they must produce,
    // oldest first.
    pixel_in_t  pix_pending[$];
    pixel_out_t expected_pixels[$];
    reg_write_t reg_writes_pending[$];

    // Our own copy of the register file; it follows the writes seen on cfg.
    rbox_pkg::rbox_cfg_t shadow_cfg;

    int pixels_issued = 0;
    int words_returned = 0;
    int reg_writes_issued = 0;
    int reg_writes_done = 0;
    int error_count = 0;

    int src_wait = 0;
    int snk_wait = 0;
    bit src_idle_on = 1'b0;
    bit snk_idle_on = 1'b0;
    bit pressure_go = 1'b0;
    logic sink_hold = 1'b0;

    // Mismatch reporting. Only the first MAX_REPORTS mismatches are printed so that
    // a badly broken block cannot flood the log, but every mismatch is counted.
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                                      words_returned, name, got, want));
    endtask

    // True when (x, y) lies inside a w by h rectangle whose corners are rounded
    // with radius r. Coordinates are relative to the rectangle's top left corner.
    function automatic bit in_rounded_rect(input int x, input int y, input int w,
                                           input int h, input int r);
        int cx;
        int cy;
        int dx;
        int dy;
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        // Straight bands through the middle need no corner test.
        if ((x >= r && x < w - r) || (y >= r && y < h - r))
            return 1'b1;
        cx = (x < r) ? r : w - r - 1;
        cy = (y < r) ? r : h - r - 1;
        dx = x - cx;
        dy = y - cy;
        return dx * dx + dy * dy <= r * r;
    endfunction

    // Composites one pixel with the current register copy: box and border
    // geometry, premultiplied background, then the ink blend where there is text.
    function automatic pixel_out_t composite_pixel(input pixel_in_t p);
        pixel_out_t res;
        int x;
        int y;
        int t;
        int inv;
        int bw;
        int box_w;
        int box_h;
        int inner_r;
        int bg_a;
        int bg_r;
        int bg_g;
        int bg_b;
        int out_a;
        int out_r;
        int out_g;
        int out_b;
        bit border;
        rbox_pkg::region_t where;

        x = int'(p.x) - INSET;
        y = int'(p.y) - INSET;
        t = int'(p.coverage);
        bw = int'(shadow_cfg.border_width);
        box_w = FRAME_W - 2 * INSET;
        box_h = FRAME_H - 2 * INSET;
        bg_a = 0;
        bg_r = 0;
        bg_g = 0;
        bg_b = 0;
        where = rbox_pkg::REGION_OUTSIDE;

        if (int'(p.x) < FRAME_W && int'(p.y) < FRAME_H &&
            in_rounded_rect(x, y, box_w, box_h, CORNER_R))
        begin
            inner_r = (CORNER_R - bw < 0) ? 0 : CORNER_R - bw;
            // The border band is the part of the box outside the shrunk inner
            // rectangle; a wide border leaves that rectangle empty.
            border = bw > 0 && !in_rounded_rect(x - bw, y - bw, box_w - 2 * bw,
                                                box_h - 2 * bw, inner_r);
            where = border ? rbox_pkg::REGION_BORDER : rbox_pkg::REGION_INTERIOR;
            bg_a = border ? int'(rbox_pkg::BORDER_ALPHA) : int'(shadow_cfg.fill_alpha);
            bg_r = int'(shadow_cfg.fill_red) * bg_a / 255;
            bg_g = int'(shadow_cfg.fill_green) * bg_a / 255;
            bg_b = int'(shadow_cfg.fill_blue) * bg_a / 255;
        end

        out_a = bg_a;
        out_r = bg_r;
        out_g = bg_g;
        out_b = bg_b;
        if (t != 0)
        begin
            inv = 255 - t;
            out_a = t + bg_a * inv / 255;
            out_r = int'(shadow_cfg.ink_red) * t / 255 + bg_r * inv / 255;
            out_g = int'(shadow_cfg.ink_green) * t / 255 + bg_g * inv / 255;
            out_b = int'(shadow_cfg.ink_blue) * t / 255 + bg_b * inv / 255;
        end

        res.alpha = out_a[7:0];
        res.red = out_r[7:0];
        res.green = out_g[7:0];
        res.blue = out_b[7:0];
        res.region = where;
        return res;
    endfunction

    // With idling off every word goes straight through; with it on, half do and the rest get a random wait.
    function automatic int draw_wait(input bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Random pixel, weighted toward the left and right ends of the box where
    // the corners and the border band sit, with some pixels past the frame.
    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            p.x = 10'($urandom_range(0, 1023));
            p.y = 7'($urandom_range(0, 127));
        end
        else if (pick <= 6)
        begin
            p.x = 10'(($urandom_range(0, 1) == 0) ? $urandom_range(10, 100)
                                                  : $urandom_range(799, 905));
            p.y = 7'($urandom_range(0, FRAME_H - 1));
        end
        else if (pick <= 8)
        begin
            p.x = 10'($urandom_range(0, FRAME_W - 1));
            p.y = 7'($urandom_range(0, FRAME_H - 1));
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            p.x = 10'($urandom_range(FRAME_W, 1023));
            p.y = 7'($urandom_range(0, 127));
        end
        else
        begin
            p.x = 10'($urandom_range(0, 1023));
            p.y = 7'($urandom_range(FRAME_H, 127));
        end
        case ($urandom_range(0, 7))
            0, 1: p.coverage = 8'd0;
            2: p.coverage = 8'd255;
            default: p.coverage = 8'($urandom_range(0, 255));
        endcase
        return p;
    endfunction

    task automatic queue_pixel(input int x, input int y, input int coverage);
        pixel_in_t p;
        p.x = 10'(x);
        p.y = 7'(y);
        p.coverage = 8'(coverage);
        pix_pending.push_back(p);
        pixels_issued++;
    endtask

    task automatic queue_reg_write(input logic [rbox_pkg::CFG_INDEX_W-1:0] index,
                                   input logic [rbox_pkg::CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.index = index;
        w.data = data;
        reg_writes_pending.push_back(w);
        reg_writes_issued++;
    endtask

    // Writes every register, then waits for the writes to land.
    task automatic load_registers(input int fr, input int fg, input int fb, input int fa,
                                  input int ir, input int ig, input int ib,
                                  input int border_data);
        queue_reg_write(rbox_pkg::REG_FILL_RED, 8'(fr));
        queue_reg_write(rbox_pkg::REG_FILL_GREEN, 8'(fg));
        queue_reg_write(rbox_pkg::REG_FILL_BLUE, 8'(fb));
        queue_reg_write(rbox_pkg::REG_FILL_ALPHA, 8'(fa));
        queue_reg_write(rbox_pkg::REG_INK_RED, 8'(ir));
        queue_reg_write(rbox_pkg::REG_INK_GREEN, 8'(ig));
        queue_reg_write(rbox_pkg::REG_INK_BLUE, 8'(ib));
        queue_reg_write(rbox_pkg::REG_BORDER_WIDTH, 8'(border_data));
        while (reg_writes_done != reg_writes_issued)
            @(posedge clk);
    endtask

    // The sender stops until every pixel so far has come back, then waits out
    // a further stretch sized from PIPE_LATENCY so that the pipeline is surely empty.
    task automatic wait_drained();
        while (words_returned != pixels_issued)
            @(posedge clk);
        repeat (PIPE_LATENCY + 3)
            @(posedge clk);
    endtask

    // Pixel driver. A pixel is offered until accepted; at acceptance its
    // expected word is computed with the registers as they stand, which is
    // safe because registers only change while nothing is in flight.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_in_t next_pix;
        bit offer;
        if (!rst_n)
        begin
            pix_if.valid <= 1'b0;
            pix_if.pixel_x <= '0;
            pix_if.pixel_y <= '0;
            pix_if.text_coverage <= '0;
            src_wait = 0;
        end
        else
        begin
            offer = pix_if.valid;
            if (pix_if.valid && pix_if.ready)
            begin
                next_pix.x = pix_if.pixel_x;
                next_pix.y = pix_if.pixel_y;
                next_pix.coverage = pix_if.text_coverage;
                expected_pixels.push_back(composite_pixel(next_pix));
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (pix_pending.size() != 0)
                begin
                    next_pix = pix_pending.pop_front();
                    pix_if.pixel_x <= next_pix.x;
                    pix_if.pixel_y <= next_pix.y;
                    pix_if.text_coverage <= next_pix.coverage;
                    offer = 1'b1;
                    src_wait = draw_wait(src_idle_on);
                end
            end
            pix_if.valid <= offer;
        end
    end

    // Result monitor. Every accepted word is checked field by field against
    // the oldest expectation. Ready drops for the drawn wait after each word,
    // and for the whole hold-off stretch.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_out_t want;
        bit take;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            snk_wait = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("word %0d arrived with nothing expected",
                                              words_returned));
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("alpha", int'(res_if.out_alpha), int'(want.alpha));
                    check_field("red", int'(res_if.out_red), int'(want.red));
                    check_field("green", int'(res_if.out_green), int'(want.green));
                    check_field("blue", int'(res_if.out_blue), int'(want.blue));
                    check_field("region", int'(res_if.region), int'(want.region));
                end
                words_returned++;
                snk_wait = draw_wait(snk_idle_on);
            end
            if (sink_hold)
                take = 1'b0;
            else if (snk_wait > 0)
            begin
                snk_wait--;
                take = 1'b0;
            end
            else
                take = 1'b1;
            res_if.ready <= take;
        end
    end

    // Register writer. The register copy moves at the same edge as the block's.
    always @(posedge clk or negedge rst_n)
    begin
        reg_write_t w;
        bit offer;
        if (!rst_n)
        begin
            cfg_if.valid <= 1'b0;
            cfg_if.index <= '0;
            cfg_if.data <= '0;
            shadow_cfg.fill_red <= rbox_pkg::RST_FILL_COLOR;
            shadow_cfg.fill_green <= rbox_pkg::RST_FILL_COLOR;
            shadow_cfg.fill_blue <= rbox_pkg::RST_FILL_COLOR;
            shadow_cfg.fill_alpha <= rbox_pkg::RST_FILL_ALPHA;
            shadow_cfg.ink_red <= rbox_pkg::RST_INK_COLOR;
            shadow_cfg.ink_green <= rbox_pkg::RST_INK_COLOR;
            shadow_cfg.ink_blue <= rbox_pkg::RST_INK_COLOR;
            shadow_cfg.border_width <= rbox_pkg::RST_BORDER_WIDTH;
        end
        else
        begin
            offer = cfg_if.valid;
            if (cfg_if.valid && cfg_if.ready)
            begin
                // The border register keeps only its low six bits; writes to
                // indexes past the last register change nothing.
                case (cfg_if.index)
                    rbox_pkg::REG_FILL_RED:     shadow_cfg.fill_red <= cfg_if.data;
                    rbox_pkg::REG_FILL_GREEN:   shadow_cfg.fill_green <= cfg_if.data;
                    rbox_pkg::REG_FILL_BLUE:    shadow_cfg.fill_blue <= cfg_if.data;
                    rbox_pkg::REG_FILL_ALPHA:   shadow_cfg.fill_alpha <= cfg_if.data;
                    rbox_pkg::REG_INK_RED:      shadow_cfg.ink_red <= cfg_if.data;
                    rbox_pkg::REG_INK_GREEN:    shadow_cfg.ink_green <= cfg_if.data;
                    rbox_pkg::REG_INK_BLUE:     shadow_cfg.ink_blue <= cfg_if.data;
                    rbox_pkg::REG_BORDER_WIDTH: shadow_cfg.border_width <= cfg_if.data[5:0];
                    default: ;
                endcase
                reg_writes_done++;
                offer = 1'b0;
            end
            if (!offer && reg_writes_pending.size() != 0)
            begin
                w = reg_writes_pending.pop_front();
                cfg_if.index <= w.index;
                cfg_if.data <= w.data;
                offer = 1'b1;
            end
            cfg_if.valid <= offer;
        end
    end

    // Long hold-off on the result side. The sender keeps offering, so the
    // pipeline fills up and pix must stall until the hold is released.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        int bw;

        // The driver, monitor and register writer take their reset values at
        // the first clock edge, while rst_n is still low.
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels under the reset registers: black fill at alpha 192,
        // white ink and no border. Frame and field extremes, the cut-off
        // corners, both sides of the box edge, and pixels past the frame,
        // with and without text on them.
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        queue_pixel(0, 0, 0);
        queue_pixel(1023, 127, 255);
        queue_pixel(16, 16, 0);
        queue_pixel(22, 22, 0);
        queue_pixel(16, 60, 0);
        queue_pixel(15, 60, 40);
        queue_pixel(883, 103, 0);
        queue_pixel(883, 60, 128);
        queue_pixel(884, 60, 0);
        queue_pixel(450, 60, 0);
        queue_pixel(450, 60, 255);
        queue_pixel(899, 119, 0);
        queue_pixel(900, 60, 200);
        queue_pixel(450, 127, 77);
        queue_pixel(341, 42, 170);
        wait_drained();

        // A four pixel border, written with stray upper bits that must be
        // dropped, and a write to an unused index that must change nothing.
        load_registers(200, 100, 50, 255, 10, 20, 30, 8'hC4);
        queue_reg_write(4'd12, 8'h3F);
        while (reg_writes_done != reg_writes_issued)
            @(posedge clk);
        queue_pixel(18, 60, 0);
        queue_pixel(20, 60, 0);
        queue_pixel(19, 60, 90);
        queue_pixel(450, 16, 0);
        queue_pixel(450, 20, 0);
        queue_pixel(24, 24, 0);
        queue_pixel(30, 30, 255);
        queue_pixel(879, 99, 0);
        queue_pixel(450, 103, 60);
        queue_pixel(1000, 100, 10);
        wait_drained();

        // Random phases, each with its own register setting. The first two are
        // the extremes; then a one pixel border, borders that leave no inner
        // radius at all, and one so wide that the inner rectangle vanishes.
        for (phase = 0; phase < PHASES; phase++)
        begin
            bw = $urandom_range(0, 63);
            case (phase)
                0: load_registers(0, 0, 0, 0, 0, 0, 0, 0);
                1: load_registers(255, 255, 255, 255, 255, 255, 255, 63);
                2: bw = 1;
                3: bw = 20;
                4: bw = 21;
                5: bw = $urandom_range(44, 45);
                default: ;
            endcase
            if (phase >= 2)
                load_registers($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255),
                               int'({2'($urandom_range(0, 3)), bw[5:0]}));
            if (phase >= 6)
            begin
                queue_reg_write(4'($urandom_range(8, 15)), 8'($urandom_range(0, 255)));
                while (reg_writes_done != reg_writes_issued)
                    @(posedge clk);
            end

            // Two phases run with no idling on either side.
            src_idle_on = !(phase == 1 || phase == 4);
            snk_idle_on = !(phase == 1 || phase == 4);

            for (n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                queue_pixel(0, 0, 0);
                void'(pix_pending.pop_back());
                pix_pending.push_back(random_pixel());
                // Halfway through one phase the sender stops until every
                // pixel so far has come back.
                if (phase == 5 && n == PIXELS_PER_PHASE / 2)
                    wait_drained();
            end
            if (phase == 1)
                pressure_go = 1'b1;
            wait_drained();
        end

        error_count += expected_pixels.size();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: rounded_box_overlay_compositor.f
hw/rtl/rbox_pkg.sv
hw/rtl/rbox_if.sv
hw/rtl/rbox_geom.sv
hw/rtl/rbox_blend.sv
hw/rtl/rounded_box_overlay_compositor.sv
sim/tb.sv
